// ===== hdl/msps_pkg.sv =====
package msps_pkg;

  // field widths
  localparam int SPEED_W    = 16;
  localparam int MS_W       = 24;
  localparam int TIME_W     = 32;
  localparam int PCT_W      = 7;
  localparam int WIN_W      = 55;
  localparam int PHASE_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 55;

  // slow window layout
  localparam int WIN_START_LSB = 0;
  localparam int WIN_DUR_LSB   = 24;
  localparam int WIN_PCT_LSB   = 48;

  localparam int SLOW_WINDOWS_DEF = 2;
  localparam int unsigned MAX_RUN_MS = 1000000;
  localparam int unsigned PCT_DIVISOR = 100;

  // x / 100 == (x * PCT_RECIP) >> PCT_SHIFT for x below 2^23
  // (target * percent peaks at 65535 * 127)
  localparam int unsigned PCT_RECIP = 10737419;
  localparam int          PCT_SHIFT = 30;

  // multiply / divide unit
  localparam int MUL_B_W        = 32;
  localparam int PROD_W         = SPEED_W + MUL_B_W;
  localparam int DIVISOR_W      = 24;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_STEPS      = PROD_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE     = 3'd0,
    PH_RAMPUP   = 3'd1,
    PH_RUN      = 3'd2,
    PH_SLOW     = 3'd3,
    PH_STOPPING = 3'd4,
    PH_WAIT     = 3'd5,
    PH_STOP     = 3'd6
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_SPEED = 3'd0,
    CFG_STOP_AFTER   = 3'd1,
    CFG_LATE_START   = 3'd2,
    CFG_RAMPUP       = 3'd3,
    CFG_STOP_RAMP    = 3'd4,
    CFG_WAIT         = 3'd5,
    CFG_SLOW_WIN0    = 3'd6,
    CFG_SLOW_WIN1    = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SEL,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_WB
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic sel;
    logic mul;
    logic div_start;
    logic commit;
  } msps_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } msps_stat_t;

endpackage

// ===== hdl/msps_item_if.sv =====
interface msps_item_if;
  import msps_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [TIME_W-1:0] now_ms;
  logic              trigger;

  modport source (output valid, kind, now_ms, trigger, input ready);
  modport sink (input valid, kind, now_ms, trigger, output ready);
endinterface

// ===== hdl/msps_result_if.sv =====
interface msps_result_if;
  import msps_pkg::*;

  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed;
  logic [PHASE_W-1:0] phase_code;
  logic               in_stop_sequence;

  modport source (output valid, speed, phase_code, in_stop_sequence, input ready);
  modport sink (input valid, speed, phase_code, in_stop_sequence, output ready);
endinterface

// ===== hdl/msps_div.sv =====
module msps_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [msps_pkg::PROD_W-1:0]    dividend,
  input  logic [msps_pkg::DIVISOR_W-1:0] divisor,
  output logic [msps_pkg::PROD_W-1:0]    quotient,
  output logic                           last
);
  import msps_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [PROD_W-1:0]    quo;
  logic [DIVISOR_W-1:0] rem_next;
  logic [PROD_W-1:0]    quo_next;

  // restoring division, DIV_RADIX_BITS quotient bits per cycle
  always_comb begin
    logic [DIVISOR_W:0] trial;
    rem_next = rem;
    quo_next = quo;
    trial    = '0;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      trial    = {rem_next, quo_next[PROD_W-1]};
      quo_next = {quo_next[PROD_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial       = trial - {1'b0, divisor};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;
  assign last     = busy && (cnt == '0);
endmodule

// ===== hdl/msps_dp.sv =====
module msps_dp #(
  parameter int SLOW_WINDOWS = msps_pkg::SLOW_WINDOWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            kind,
  input  logic [msps_pkg::TIME_W-1:0]     now_ms,
  input  logic                            trigger,
  input  logic                            cfg_write,
  input  logic [msps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  msps_pkg::msps_cmd_t             cmd,
  output msps_pkg::msps_stat_t            stat,
  msps_result_if.source                   result
);
  import msps_pkg::*;

  // configuration
  logic [SPEED_W-1:0] goal_speed;
  logic [MS_W-1:0]    stop_after_ms;
  logic [MS_W-1:0]    late_start_ms;
  logic [MS_W-1:0]    rampup_ms;
  logic [MS_W-1:0]    decel_ms;
  logic [MS_W-1:0]    wait_ms;
  logic [WIN_W-1:0]   slow_win [SLOW_WINDOWS];

  // sequencer state
  phase_t             phase;
  logic [TIME_W-1:0]  start_time;
  logic [TIME_W-1:0]  phase_start_time;
  logic [SPEED_W-1:0] current_speed;
  logic [SPEED_W-1:0] decel_start_speed;
  logic               stop_pending;

  phase_t             phase_next;
  logic [TIME_W-1:0]  start_time_next;
  logic [TIME_W-1:0]  phase_start_time_next;
  logic [SPEED_W-1:0] current_speed_next;
  logic [SPEED_W-1:0] decel_start_speed_next;
  logic               stop_pending_next;

  // request and working registers
  logic                 it_kind;
  logic [TIME_W-1:0]    it_now;
  logic                 it_trig;
  logic [TIME_W-1:0]    t_r;
  logic [TIME_W-1:0]    p_r;
  logic                 pend_r;
  logic                 hit_r;
  logic                 stop_due_r;
  logic [SPEED_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [DIVISOR_W-1:0] divisor_r;
  logic [PROD_W-1:0]    product;
  logic [PROD_W-1:0]    quotient;
  logic                 div_last;

  logic                 hit;
  logic [PCT_W-1:0]     pct;
  logic                 stop_due;

  // result register
  logic               res_valid;
  logic [SPEED_W-1:0] res_speed;
  phase_t             res_phase;
  logic               res_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_speed    <= '0;
      stop_after_ms <= '1;
      late_start_ms <= '0;
      rampup_ms     <= MS_W'(1);
      decel_ms      <= '0;
      wait_ms       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TARGET_SPEED: goal_speed    <= cfg_data[SPEED_W-1:0];
        CFG_STOP_AFTER:   stop_after_ms <= cfg_data[MS_W-1:0];
        CFG_LATE_START:   late_start_ms <= cfg_data[MS_W-1:0];
        CFG_RAMPUP:       rampup_ms     <= cfg_data[MS_W-1:0];
        CFG_STOP_RAMP:    decel_ms      <= cfg_data[MS_W-1:0];
        CFG_WAIT:         wait_ms       <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < SLOW_WINDOWS; w++) begin
        slow_win[w] <= '0;
      end
    end else begin
      for (int w = 0; w < SLOW_WINDOWS; w++) begin
        if (cfg_write && (cfg_index == CFG_IDX_W'(int'(CFG_SLOW_WIN0) + w))) begin
          slow_win[w] <= cfg_data[WIN_W-1:0];
        end
      end
    end
  end

  // capture, then elapsed times
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_kind <= kind;
      it_now  <= now_ms;
      it_trig <= trigger;
    end
    if (cmd.prep) begin
      t_r    <= it_now - start_time;
      p_r    <= it_now - phase_start_time;
      pend_r <= stop_pending | it_trig;
    end
  end

  // first matching slow window, lowest index wins
  always_comb begin
    logic [MS_W-1:0] ws;
    logic [MS_W:0]   we;
    hit = 1'b0;
    pct = '0;
    ws  = '0;
    we  = '0;
    for (int w = 0; w < SLOW_WINDOWS; w++) begin
      ws = slow_win[w][WIN_START_LSB +: MS_W];
      we = {1'b0, ws} + {1'b0, slow_win[w][WIN_DUR_LSB +: MS_W]};
      if (!hit && (t_r >= TIME_W'(ws)) && (t_r < TIME_W'(we))) begin
        hit = 1'b1;
        pct = slow_win[w][WIN_PCT_LSB +: PCT_W];
      end
    end
  end

  assign stop_due = (t_r >= TIME_W'(stop_after_ms)) || (t_r >= TIME_W'(MAX_RUN_MS));

  // operand select for the shared multiply/divide
  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      hit_r      <= hit;
      stop_due_r <= stop_due;
      case (phase)
        PH_RAMPUP: begin
          mul_a     <= goal_speed;
          mul_b     <= p_r;
          divisor_r <= rampup_ms;
        end
        PH_STOPPING: begin
          mul_a     <= decel_start_speed;
          mul_b     <= MUL_B_W'(decel_ms - p_r[MS_W-1:0]);
          divisor_r <= decel_ms;
        end
        default: begin
          // percent scaling: reciprocal folded into the second operand
          mul_a <= goal_speed;
          mul_b <= MUL_B_W'(pct) * MUL_B_W'(PCT_RECIP);
        end
      endcase
    end
    if (cmd.mul) begin
      product <= mul_a * mul_b;
    end
  end

  msps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (product),
    .divisor  (divisor_r),
    .quotient (quotient),
    .last     (div_last)
  );

  // next state from the finished request
  always_comb begin
    phase_next             = phase;
    start_time_next        = start_time;
    phase_start_time_next  = phase_start_time;
    current_speed_next     = current_speed;
    decel_start_speed_next = decel_start_speed;
    stop_pending_next      = pend_r;
    if (it_kind == KIND_START) begin
      phase_next             = PH_IDLE;
      start_time_next        = it_now;
      phase_start_time_next  = it_now;
      current_speed_next     = '0;
      decel_start_speed_next = '0;
      stop_pending_next      = 1'b0;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (t_r >= TIME_W'(late_start_ms)) begin
            phase_next            = PH_RAMPUP;
            phase_start_time_next = it_now;
          end
        end
        PH_RAMPUP: begin
          // ramp saturates at target before narrowing
          if ((rampup_ms == '0) || (quotient >= PROD_W'(goal_speed))) begin
            current_speed_next    = goal_speed;
            phase_next            = PH_RUN;
            phase_start_time_next = it_now;
          end else begin
            current_speed_next = quotient[SPEED_W-1:0];
          end
        end
        PH_RUN, PH_SLOW: begin
          if (pend_r) begin
            stop_pending_next      = 1'b0;
            phase_next             = PH_STOPPING;
            phase_start_time_next  = it_now;
            decel_start_speed_next = current_speed;
          end else begin
            if (hit_r) begin
              phase_next         = PH_SLOW;
              current_speed_next = (product[PROD_W-1:PCT_SHIFT+SPEED_W] != '0) ? '1
                                   : product[PCT_SHIFT +: SPEED_W];
            end else begin
              phase_next         = PH_RUN;
              current_speed_next = goal_speed;
            end
            if (stop_due_r) begin
              phase_next         = PH_STOP;
              current_speed_next = '0;
            end
          end
        end
        PH_STOPPING: begin
          if (p_r >= TIME_W'(decel_ms)) begin
            phase_next            = PH_WAIT;
            phase_start_time_next = it_now;
            current_speed_next    = '0;
          end else begin
            current_speed_next = quotient[SPEED_W-1:0];
          end
        end
        PH_WAIT: begin
          if (p_r >= TIME_W'(wait_ms)) begin
            phase_next            = PH_RAMPUP;
            phase_start_time_next = it_now;
          end
        end
        default: begin
          current_speed_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      start_time        <= '0;
      phase_start_time  <= '0;
      current_speed     <= '0;
      decel_start_speed <= '0;
      stop_pending      <= 1'b0;
    end else if (cmd.commit) begin
      phase             <= phase_next;
      start_time        <= start_time_next;
      phase_start_time  <= phase_start_time_next;
      current_speed     <= current_speed_next;
      decel_start_speed <= decel_start_speed_next;
      stop_pending      <= stop_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_speed <= current_speed_next;
      res_phase <= phase_next;
      res_flag  <= (phase_next == PH_STOPPING) || (phase_next == PH_WAIT);
    end
  end

  assign result.valid            = res_valid;
  assign result.speed            = res_speed;
  assign result.phase_code       = res_phase;
  assign result.in_stop_sequence = res_flag;

  assign stat.need_div = (it_kind == KIND_STEP)
                         && (phase inside {PH_RAMPUP, PH_STOPPING});
  assign stat.div_last = div_last;
  assign stat.out_free = !res_valid || result.ready;
endmodule

// ===== hdl/msps_ctrl.sv =====
module msps_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  msps_pkg::msps_stat_t stat,
  output msps_pkg::msps_cmd_t  cmd
);
  import msps_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_PREP;
      ST_PREP: state_next = ST_SEL;
      ST_SEL:  state_next = ST_MUL;
      ST_MUL:  state_next = stat.need_div ? ST_LOAD : ST_WB;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV:  if (stat.div_last) state_next = ST_WB;
      ST_WB:   if (stat.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_PREP: cmd.prep      = 1'b1;
      ST_SEL:  cmd.sel       = 1'b1;
      ST_MUL:  cmd.mul       = 1'b1;
      ST_LOAD: cmd.div_start = 1'b1;
      ST_WB:   cmd.commit    = stat.out_free;
      default: ;
    endcase
  end
endmodule

// ===== hdl/motor_speed_profile_sequencer_unit.sv =====
// Channel   Dir  Handshake     Payload
// item      in   valid/ready   kind, now_ms, trigger
// result    out  valid/ready   speed, phase_code, in_stop_sequence
// cfg       in   cfg_write     cfg_index, cfg_data (no read-back)
//
// A request needs no division for start, idle, run, slow, wait and stop
// steps; ramp-up and stopping steps also pass through the 48/24-bit
// restoring divider, two quotient bits per cycle. Run/slow percent
// scaling is a reciprocal multiply.
// One request is in flight at a time; a new one is taken while the
// previous result still sits in the output register.
// A stalled result holds the write-back step until the output frees.
// rst is synchronous: phase idle, times and speeds zero, registers at
// their reset values, no result pending.
module motor_speed_profile_sequencer_unit #(
  parameter int SLOW_WINDOWS = msps_pkg::SLOW_WINDOWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  msps_item_if.sink                       item,
  msps_result_if.source                   result,
  input  logic                            cfg_write,
  input  logic [msps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import msps_pkg::*;

  msps_cmd_t  cmd;
  msps_stat_t stat;
  logic       in_ready;

  // sequencer: capture, elapsed times, operand select, multiply,
  // optional divide, write-back
  msps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // config registers, profile state, shared multiply/divide, output register
  msps_dp #(
    .SLOW_WINDOWS (SLOW_WINDOWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .kind      (item.kind),
    .now_ms    (item.now_ms),
    .trigger   (item.trigger),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  assign item.ready = in_ready;
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import msps_pkg::*;

  localparam int IDLE_MAX     = 16;    // per-request gap / stall ceiling
  localparam int LONG_HOLD    = 250;   // receiver back-off, long enough to fill the block
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all before giving up
  localparam int DRAIN_CYCLES = 40;    // idle time after the drain, longer than the slowest request
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 110;

  localparam logic [MS_W-1:0]       MS_MAX  = {MS_W{1'b1}};
  localparam logic [SPEED_W-1:0]    SPD_MAX = {SPEED_W{1'b1}};
  localparam logic [CFG_DATA_W-1:0] WIN_MAX = {CFG_DATA_W{1'b1}};

  typedef struct {
    logic [SPEED_W-1:0] speed;
    phase_t             phase;
    logic               in_seq;
  } speed_cmd_t;

  // Shadow of the sequencer: registers, phase machine, and the queue of
  // speed commands still owed by the block.
  class speed_profile_tracker;
    logic [SPEED_W-1:0] target;
    logic [MS_W-1:0]    stop_after, late_start, rampup, stop_ramp, wait_len;
    logic [WIN_W-1:0]   window [SLOW_WINDOWS_DEF];

    phase_t             phase;
    logic [TIME_W-1:0]  start_time, phase_start;
    logic [SPEED_W-1:0] cur_speed, decel_speed;
    logic               stop_latch;

    speed_cmd_t due_cmds [$];
    int errors;

    function new();
      target      = '0;
      stop_after  = MS_MAX;
      late_start  = '0;
      rampup      = MS_W'(1);
      stop_ramp   = '0;
      wait_len    = '0;
      foreach (window[w]) window[w] = '0;
      phase       = PH_IDLE;
      start_time  = '0;
      phase_start = '0;
      cur_speed   = '0;
      decel_speed = '0;
      stop_latch  = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TARGET_SPEED: target     = data[SPEED_W-1:0];
        CFG_STOP_AFTER:   stop_after = data[MS_W-1:0];
        CFG_LATE_START:   late_start = data[MS_W-1:0];
        CFG_RAMPUP:       rampup     = data[MS_W-1:0];
        CFG_STOP_RAMP:    stop_ramp  = data[MS_W-1:0];
        CFG_WAIT:         wait_len   = data[MS_W-1:0];
        CFG_SLOW_WIN0:    window[0]  = data[WIN_W-1:0];
        CFG_SLOW_WIN1:    window[1]  = data[WIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void enter_phase(phase_t ph, logic [TIME_W-1:0] now);
      phase       = ph;
      phase_start = now;
    endfunction

    // first window hit wins; the stop check overrides everything
    function void slow_or_run(logic [TIME_W-1:0] t);
      logic [TIME_W-1:0] lo, hi, scaled;
      bit hit;
      hit = 1'b0;
      for (int w = 0; w < SLOW_WINDOWS_DEF; w++) begin
        lo = TIME_W'(window[w][WIN_DUR_LSB-1:WIN_START_LSB]);
        hi = lo + TIME_W'(window[w][WIN_PCT_LSB-1:WIN_DUR_LSB]);
        if (!hit && t >= lo && t < hi) begin
          scaled = (TIME_W'(target) * TIME_W'(window[w][WIN_W-1:WIN_PCT_LSB])) / PCT_DIVISOR;
          hit = 1'b1;
          phase = PH_SLOW;
          cur_speed = (scaled[TIME_W-1:SPEED_W] != 0) ? SPD_MAX : scaled[SPEED_W-1:0];
        end
      end
      if (!hit) begin
        phase = PH_RUN;
        cur_speed = target;
      end
      if (t >= stop_after || t >= MAX_RUN_MS) begin
        phase = PH_STOP;
        cur_speed = '0;
      end
    endfunction

    function void take_request(logic kind, logic [TIME_W-1:0] now, logic trig);
      logic [TIME_W-1:0] t, p;
      logic [63:0] ramp, rem;
      speed_cmd_t cmd;
      if (kind == KIND_START) begin
        phase       = PH_IDLE;
        start_time  = now;
        phase_start = now;
        cur_speed   = '0;
        decel_speed = '0;
        stop_latch  = 1'b0;
      end else begin
        t = now - start_time;
        p = now - phase_start;
        stop_latch = stop_latch | trig;
        case (phase)
          PH_IDLE: if (t >= late_start) enter_phase(PH_RAMPUP, now);
          PH_RAMPUP: begin
            if (rampup == 0) ramp = 64'(target);
            else ramp = (64'(target) * 64'(p)) / 64'(rampup);
            if (ramp >= 64'(target)) begin
              ramp = 64'(target);
              enter_phase(PH_RUN, now);
            end
            cur_speed = ramp[SPEED_W-1:0];
          end
          PH_RUN, PH_SLOW: begin
            if (stop_latch) begin
              stop_latch = 1'b0;
              enter_phase(PH_STOPPING, now);
              decel_speed = cur_speed;
            end else begin
              slow_or_run(t);
            end
          end
          PH_STOPPING: begin
            if (p >= stop_ramp) begin
              enter_phase(PH_WAIT, now);
              cur_speed = '0;
            end else begin
              rem = 64'(stop_ramp - p);
              ramp = (64'(decel_speed) * rem) / 64'(stop_ramp);
              cur_speed = ramp[SPEED_W-1:0];
            end
          end
          PH_WAIT: if (p >= wait_len) enter_phase(PH_RAMPUP, now);
          default: cur_speed = '0;
        endcase
      end
      cmd.speed  = cur_speed;
      cmd.phase  = phase;
      cmd.in_seq = (phase == PH_STOPPING || phase == PH_WAIT);
      due_cmds.push_back(cmd);
    endfunction

    function void match_command(logic [SPEED_W-1:0] spd, logic [PHASE_W-1:0] code,
                                logic flag);
      speed_cmd_t want;
      if (due_cmds.size() == 0) begin
        if (errors < REPORT_LIMIT)
          $display("%0t: result with nothing pending: speed %0d phase %0d stop_seq %0b",
                   $time, spd, code, flag);
        errors++;
        return;
      end
      want = due_cmds.pop_front();
      if (spd !== want.speed || code !== want.phase || flag !== want.in_seq) begin
        if (errors < REPORT_LIMIT)
          $display("%0t: mismatch exp/act: speed %0d/%0d phase %0d/%0d stop_seq %0b/%0b",
                   $time, want.speed, spd, want.phase, code, want.in_seq, flag);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  msps_item_if   item_ch ();
  msps_result_if result_ch ();

  speed_profile_tracker board = new();

  // register image written as a whole at each phase change
  logic [CFG_DATA_W-1:0] profile [8];
  logic [TIME_W-1:0]     clock_ms;   // running millisecond time of the current sequence
  int gap_max   = IDLE_MAX;
  int stall_max = IDLE_MAX;
  bit hold_request = 1'b0;           // asks the receiver for one long back-off

  motor_speed_profile_sequencer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Everything the scoreboard sees is taken at the rising edge, from values
  // that were settled at the preceding falling edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) board.set_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (item_ch.valid && item_ch.ready)
        board.take_request(item_ch.kind, item_ch.now_ms, item_ch.trigger);
      if (result_ch.valid && result_ch.ready)
        board.match_command(result_ch.speed, result_ch.phase_code,
                            result_ch.in_stop_sequence);
    end
  end

  // Receiver: random stall before each result, or the long hold when asked.
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        stall = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        stall = $urandom_range(stall_max, 0);
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // Watchdog: no handshake on either channel for too long means a hang.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // Offer one request after a random gap; valid stays high if the gap is zero.
  task automatic send_request(logic kind, logic [TIME_W-1:0] now, logic trig);
    int gap;
    gap = $urandom_range(gap_max, 0);
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.kind    <= kind;
    item_ch.now_ms  <= now;
    item_ch.trigger <= trig;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic start_at(logic [TIME_W-1:0] at, logic trig);
    clock_ms = at;
    send_request(KIND_START, clock_ms, trig);
  endtask

  task automatic step_ms(logic [TIME_W-1:0] adv, logic trig);
    clock_ms = clock_ms + adv;
    send_request(KIND_STEP, clock_ms, trig);
  endtask

  // Sender pause: nothing offered until every owed command is back.
  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (board.due_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic program_profile();
    for (int i = 0; i < $size(profile); i++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= profile[i];
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] slow_window(logic [MS_W-1:0] first_ms,
                                                        logic [MS_W-1:0] span_ms,
                                                        logic [PCT_W-1:0] pct);
    return {pct, span_ms, first_ms};
  endfunction

  // Short times keep the machine cycling through its phases; the big jumps,
  // rare but frequent in wide mode, reach the stop time and the run limit.
  function automatic logic [TIME_W-1:0] pick_advance(bit wide);
    int roll;
    roll = $urandom_range(99, 0);
    if (wide && roll < 40) return $urandom_range(MS_MAX, 0);
    if (roll < 55) return $urandom_range(3, 0);
    if (roll < 85) return $urandom_range(20, 4);
    if (roll < 98) return $urandom_range(200, 21);
    if (roll < 99) return $urandom_range(1100000, 0);
    return MAX_RUN_MS;
  endfunction

  function automatic void choose_profile(int ph);
    case (ph)
      0: begin
        // all registers at zero
        foreach (profile[i]) profile[i] = '0;
      end
      1: begin
        // all registers at their maximum
        profile[CFG_TARGET_SPEED] = CFG_DATA_W'(SPD_MAX);
        profile[CFG_STOP_AFTER]   = CFG_DATA_W'(MS_MAX);
        profile[CFG_LATE_START]   = CFG_DATA_W'(MS_MAX);
        profile[CFG_RAMPUP]       = CFG_DATA_W'(MS_MAX);
        profile[CFG_STOP_RAMP]    = CFG_DATA_W'(MS_MAX);
        profile[CFG_WAIT]         = CFG_DATA_W'(MS_MAX);
        profile[CFG_SLOW_WIN0]    = WIN_MAX;
        profile[CFG_SLOW_WIN1]    = WIN_MAX;
      end
      default: begin
        profile[CFG_TARGET_SPEED] = ($urandom_range(99, 0) < 15) ? CFG_DATA_W'(SPD_MAX) :
                                    CFG_DATA_W'($urandom_range(SPD_MAX, 0));
        profile[CFG_STOP_AFTER]   = ($urandom_range(99, 0) < 15) ? CFG_DATA_W'(MS_MAX) :
                                    CFG_DATA_W'($urandom_range(3000, 100));
        profile[CFG_LATE_START]   = CFG_DATA_W'($urandom_range(20, 0));
        profile[CFG_RAMPUP]       = ($urandom_range(99, 0) < 10) ? '0 :
                                    CFG_DATA_W'($urandom_range(40, 1));
        profile[CFG_STOP_RAMP]    = ($urandom_range(99, 0) < 10) ? '0 :
                                    CFG_DATA_W'($urandom_range(30, 1));
        profile[CFG_WAIT]         = CFG_DATA_W'($urandom_range(20, 0));
        profile[CFG_SLOW_WIN0]    = slow_window(MS_W'($urandom_range(300, 0)),
                                      ($urandom_range(99, 0) < 20) ? MS_W'(0) :
                                      MS_W'($urandom_range(120, 1)),
                                      PCT_W'($urandom_range(127, 0)));
        profile[CFG_SLOW_WIN1]    = slow_window(MS_W'($urandom_range(300, 0)),
                                      ($urandom_range(99, 0) < 20) ? MS_W'(0) :
                                      MS_W'($urandom_range(120, 1)),
                                      PCT_W'($urandom_range(127, 0)));
      end
    endcase
  endfunction

  // Mostly well-formed runs (start, then steps with occasional triggers),
  // with some restarts and fully random noise requests mixed in.
  task automatic random_phase(int ph);
    int roll;
    start_at(clock_ms + $urandom_range(50, 0), 1'($urandom_range(1, 0)));
    for (int k = 1; k < PHASE_ITEMS; k++) begin
      if (ph == 3 && k == 20) hold_request = 1'b1;  // sender keeps going meanwhile
      if (ph == 4 && k == PHASE_ITEMS / 2) wait_drained();
      roll = $urandom_range(99, 0);
      if (roll < 3)
        start_at((roll == 0) ? $urandom : clock_ms + $urandom_range(50, 0),
                 1'($urandom_range(1, 0)));
      else if (roll < 7)
        send_request(1'($urandom_range(1, 0)), $urandom, 1'($urandom_range(1, 0)));
      else
        step_ms(pick_advance(ph == 1), $urandom_range(99, 0) < 8);
    end
  endtask

  initial begin
    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.kind    = KIND_START;
    item_ch.now_ms  = '0;
    item_ch.trigger = 1'b0;
    cfg_write       = 1'b0;
    cfg_index       = CFG_TARGET_SPEED;
    cfg_data        = '0;
    clock_ms        = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // steps before any start, reset registers: time base is zero
    step_ms(3, 1'b0);
    step_ms(4, 1'b1);

    // directed profile: short ramp, two overlapping windows, the second
    // above 100 percent so it saturates; time base just below the wrap
    wait_drained();
    profile[CFG_TARGET_SPEED] = CFG_DATA_W'(60000);
    profile[CFG_STOP_AFTER]   = CFG_DATA_W'(5000);
    profile[CFG_LATE_START]   = CFG_DATA_W'(5);
    profile[CFG_RAMPUP]       = CFG_DATA_W'(10);
    profile[CFG_STOP_RAMP]    = CFG_DATA_W'(8);
    profile[CFG_WAIT]         = CFG_DATA_W'(4);
    profile[CFG_SLOW_WIN0]    = slow_window(MS_W'(40), MS_W'(10), PCT_W'(50));
    profile[CFG_SLOW_WIN1]    = slow_window(MS_W'(45), MS_W'(20), PCT_W'(127));
    program_profile();
    start_at(32'hFFFF_FFF0, 1'b1);  // trigger on a start is dropped
    step_ms(2, 1'b0);               // still idle
    step_ms(3, 1'b0);               // late start over, ramp begins
    step_ms(4, 1'b0);
    step_ms(5, 1'b0);
    step_ms(1, 1'b0);               // ramp done, run
    step_ms(30, 1'b0);              // first window
    step_ms(5, 1'b0);               // second window, saturated
    step_ms(20, 1'b0);              // back to run
    step_ms(1, 1'b1);               // trigger taken, stopping
    step_ms(3, 1'b0);
    step_ms(5, 1'b1);               // wait; trigger latched for later
    step_ms(4, 1'b0);               // ramp-up again
    step_ms(20, 1'b0);              // run with latch still set
    step_ms(1, 1'b0);               // latch consumed
    step_ms(8, 1'b0);
    step_ms(4, 1'b0);
    step_ms(10, 1'b0);
    step_ms(6000, 1'b0);            // past stop time: final stop
    step_ms(1, 1'b1);
    start_at(0, 1'b0);
    step_ms(32'hFFFF_FFFF, 1'b0);   // time word at its maximum
    step_ms(1, 1'b0);               // and wrapped to zero

    // zero ramp-up, zero stop ramp, zero wait, a disabled window and a
    // zero-percent window; then the run limit
    wait_drained();
    profile[CFG_TARGET_SPEED] = CFG_DATA_W'(SPD_MAX);
    profile[CFG_STOP_AFTER]   = CFG_DATA_W'(MS_MAX);
    profile[CFG_LATE_START]   = '0;
    profile[CFG_RAMPUP]       = '0;
    profile[CFG_STOP_RAMP]    = '0;
    profile[CFG_WAIT]         = '0;
    profile[CFG_SLOW_WIN0]    = slow_window(MS_W'(0), MS_W'(0), PCT_W'(100));
    profile[CFG_SLOW_WIN1]    = slow_window(MS_W'(0), MS_MAX, PCT_W'(0));
    program_profile();
    start_at(100, 1'b0);
    step_ms(0, 1'b0);
    step_ms(0, 1'b0);
    step_ms(1, 1'b0);
    step_ms(1, 1'b1);
    step_ms(0, 1'b0);
    step_ms(0, 1'b0);
    step_ms(0, 1'b0);
    step_ms(MAX_RUN_MS, 1'b0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      choose_profile(ph);
      program_profile();
      gap_max   = (ph % 3 == 2) ? 0 : IDLE_MAX;
      stall_max = (ph % 3 == 2 || ph == 6) ? 0 : IDLE_MAX;
      random_phase(ph);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.due_cmds.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/msps_pkg.sv
hdl/msps_item_if.sv
hdl/msps_result_if.sv
hdl/msps_div.sv
hdl/msps_dp.sv
hdl/msps_ctrl.sv
hdl/motor_speed_profile_sequencer_unit.sv
tb/sv/testbench.sv
